// File: rtl/tctf_pkg.sv
// ----------------------------------------------------------------------------
// tctf_pkg - shared types and constants of the complementary tilt filter
// Field widths, CORDIC word formats, the arctangent table and the
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tctf_pkg;

    localparam int IN_W     = 16;   // raw IMU sample
    localparam int XY_W     = 35;   // CORDIC x/y: sample * 2^16 plus gain headroom
    localparam int Z_W      = 25;   // CORDIC angle, 1/65536 degree
    localparam int ANG_W    = 17;   // accel angle, 1/256 degree
    localparam int SUM_W    = 19;   // accel angle before the wrap
    localparam int TILT_W   = 22;   // filtered angle, 1/256 degree
    localparam int ALPHA_W  = 16;
    localparam int SCALE_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int CORDIC_MAX = 24;  // length of the arctangent table
    localparam int ATAN_W     = 22;

    // atan(2^-i) in 1/65536 degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_WEIGHT = 2'd0,
        REG_GYRO_SCALE    = 2'd1,
        REG_ACC_X_OFFSET  = 2'd2,
        REG_ACC_Y_OFFSET  = 2'd3
    } t_cfg_idx;

    // one vector on its way through the CORDIC cell row
    typedef struct packed {
        logic                   zero;   // atan2(0,0): result forced to 0
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic_vec;

    // control from the sequencer to a filter lane
    typedef struct packed {
        logic start;    // operands valid, begin a filter pass
        logic commit;   // result taken, store it as the new angle
    } t_filt_ctrl;

endpackage

`default_nettype wire

// File: rtl/tctf_if.sv
// ----------------------------------------------------------------------------
// tctf_if - channel interfaces of the complementary tilt filter
// Sample input, tilt result output and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tctf_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, gyro_x, gyro_y, acc_x, acc_y, acc_z, input ready);
    modport sink   (input valid, gyro_x, gyro_y, acc_x, acc_y, acc_z, output ready);
endinterface

interface tctf_out_if;
    logic              valid;
    logic              ready;
    logic signed [21:0] tilt_x;
    logic signed [21:0] tilt_y;
    logic signed [16:0] accel_angle_x;
    logic signed [16:0] accel_angle_y;

    modport source (output valid, tilt_x, tilt_y, accel_angle_x, accel_angle_y,
                    input ready);
    modport sink   (input valid, tilt_x, tilt_y, accel_angle_x, accel_angle_y,
                    output ready);
endinterface

interface tctf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tctf_cordic_cell.sv
// ----------------------------------------------------------------------------
// tctf_cordic_cell - one vectoring CORDIC iteration
// Rotates the incoming vector toward y = 0 by atan(2^-STEP) and registers
// the result for the next cell of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module tctf_cordic_cell
    import tctf_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_cordic_vec i_vec,
    output logic             o_valid,
    output t_cordic_vec      o_vec
);

    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic signed [Z_W-1:0]  w_atan;
    t_cordic_vec            n_vec;
    logic                   r_valid;
    t_cordic_vec            r_vec;

    assign w_xs   = $signed(i_vec.x) >>> STEP;
    assign w_ys   = $signed(i_vec.y) >>> STEP;
    assign w_atan = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[STEP]});

    always_comb begin
        n_vec      = i_vec;
        if (!i_vec.y[XY_W-1]) begin
            n_vec.x = i_vec.x + w_ys;
            n_vec.y = i_vec.y - w_xs;
            n_vec.z = i_vec.z + w_atan;
        end else begin
            n_vec.x = i_vec.x - w_ys;
            n_vec.y = i_vec.y + w_xs;
            n_vec.z = i_vec.z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

// File: rtl/tctf_filter_axis.sv
// ----------------------------------------------------------------------------
// tctf_filter_axis - complementary filter of one tilt axis
// Holds the axis angle. Four pipeline steps: gyro*scale, add to angle,
// the two weighted products, then sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tctf_filter_axis
    import tctf_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_filt_ctrl                i_ctrl,
    input  wire logic signed [IN_W-1:0]    i_gyro,
    input  wire logic signed [ANG_W-1:0]   i_acc,
    input  wire logic [ALPHA_W-1:0]        i_alpha,
    input  wire logic [SCALE_W-1:0]        i_scale,
    output logic                           o_done,
    output logic signed [TILT_W-1:0]       o_angle
);

    localparam int P1_W = IN_W + SCALE_W + 1;         // 41
    localparam int S_W  = P1_W;                       // 41
    localparam int T1_W = ALPHA_W + 1 + S_W;          // 58
    localparam int WA_W = ALPHA_W + 2;                // 18
    localparam int T2_W = WA_W + ANG_W;               // 35
    localparam int T_W  = T1_W + 1;                   // 59
    localparam int R_W  = T_W - 32;                   // 27
    localparam logic signed [R_W-1:0] LIM_HI = R_W'(1048576);
    localparam logic signed [R_W-1:0] LIM_LO = -R_W'(1048576);

    logic [3:0]               r_vld;
    logic signed [P1_W-1:0]   r_p1;
    logic signed [ANG_W-1:0]  r_acc;
    logic signed [S_W-1:0]    r_s;
    logic signed [T1_W-1:0]   r_t1;
    logic signed [T2_W-1:0]   r_t2;
    logic signed [TILT_W-1:0] r_next;
    logic signed [TILT_W-1:0] r_angle;

    logic signed [S_W-1:0]    w_ang_ext;
    logic signed [WA_W-1:0]   w_wa;
    logic signed [T_W-1:0]    w_t;
    logic signed [T_W-1:0]    w_tr;
    logic signed [R_W-1:0]    w_r;
    logic signed [TILT_W-1:0] n_next;

    assign w_ang_ext = {{(S_W-TILT_W-16){r_angle[TILT_W-1]}}, r_angle, 16'b0};
    assign w_wa      = $signed(WA_W'(18'd65536 - {2'b00, i_alpha}));
    assign w_t       = $signed({r_t1[T1_W-1], r_t1})
                     + $signed({{(T_W-T2_W-16){r_t2[T2_W-1]}}, r_t2, 16'b0});
    assign w_tr      = w_t + $signed({{(T_W-32){1'b0}}, 32'h8000_0000});
    assign w_r       = w_tr[T_W-1:32];

    always_comb begin
        if (w_r > LIM_HI) begin
            n_next = TILT_W'(LIM_HI);
        end else if (w_r < LIM_LO) begin
            n_next = TILT_W'(LIM_LO);
        end else begin
            n_next = w_r[TILT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_angle <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_ctrl.start};
            if (i_ctrl.commit) begin
                r_angle <= r_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_p1  <= $signed(i_gyro) * $signed({1'b0, i_scale});
            r_acc <= i_acc;
        end
        if (r_vld[0]) begin
            r_s <= w_ang_ext + r_p1;
        end
        if (r_vld[1]) begin
            r_t1 <= $signed({1'b0, i_alpha}) * r_s;
            r_t2 <= w_wa * r_acc;
        end
        if (r_vld[2]) begin
            r_next <= n_next;
        end
    end

    assign o_done  = r_vld[3];
    assign o_angle = r_next;

endmodule

`default_nettype wire

// File: rtl/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter - accelerometer/gyro tilt estimator
// Two atan2 evaluations through a row of CORDIC cells, offset and wrap,
// then a complementary filter on each axis.
// ----------------------------------------------------------------------------
//  channel   | dir | transaction
//  i_sample  | in  | one IMU sample: gyro_x, gyro_y, acc_x, acc_y, acc_z
//  o_tilt    | out | tilt_x, tilt_y, accel_angle_x, accel_angle_y
//  i_cfg     | in  | register write: index, data (always ready)
//
//  One sample at a time: an accepted sample passes the cell row (two vectors),
//  the wrap, the four filter steps, the commit state and the output load
//  before o_tilt.valid rises. The next sample is taken once the result sits
//  in the output register, even while o_tilt is stalled; a stall only delays
//  the load of a following result. Reset clears the angles and loads register
//  defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_tilt_filter
    import tctf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tctf_in_if.sink    i_sample,
    tctf_out_if.source o_tilt,
    tctf_cfg_if.sink   i_cfg
);

    localparam int N_CELLS = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
    localparam logic signed [Z_W-1:0]   Z_QUARTER = Z_W'(90 * 65536);
    localparam logic signed [SUM_W-1:0] HALF_TURN = SUM_W'(46080);
    localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(92160);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FEED_A = 6'b000010,
        S_FEED_B = 6'b000100,
        S_WAIT   = 6'b001000,
        S_FILTER = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [ALPHA_W-1:0]      r_alpha;
    logic [SCALE_W-1:0]      r_scale;
    logic signed [ANG_W-1:0] r_off_x;
    logic signed [ANG_W-1:0] r_off_y;

    // latched sample
    logic signed [IN_W-1:0] r_gx, r_gy, r_ax, r_ay, r_az;

    // cell row
    logic        w_vld [0:N_CELLS];
    t_cordic_vec w_vec [0:N_CELLS];
    logic signed [IN_W-1:0] w_num;
    logic signed [XY_W-1:0] w_num_s, w_den_s;

    // post stage
    logic                    r_got_a;
    logic signed [ANG_W-1:0] r_acc_x, r_acc_y;
    logic signed [Z_W-1:0]   w_zr;
    logic signed [ANG_W-1:0] w_q;
    logic signed [ANG_W-1:0] w_off;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [ANG_W-1:0] w_wrap;
    logic                    r_filt_start;

    // filter lanes and output
    t_filt_ctrl               w_ctrl;
    logic                     w_done_x, w_done_y;
    logic signed [TILT_W-1:0] w_ang_x, w_ang_y;
    logic                     w_load;
    logic                     r_out_valid;
    logic signed [TILT_W-1:0] r_tilt_x, r_tilt_y;
    logic signed [ANG_W-1:0]  r_out_ax, r_out_ay;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_W'(64225);
            r_scale <= SCALE_W'(23488);
            r_off_x <= -ANG_W'(819);
            r_off_y <= ANG_W'(768);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                REG_FILTER_WEIGHT: r_alpha <= i_cfg.data[ALPHA_W-1:0];
                REG_GYRO_SCALE:    r_scale <= i_cfg.data[SCALE_W-1:0];
                REG_ACC_X_OFFSET:  r_off_x <= $signed(i_cfg.data[ANG_W-1:0]);
                REG_ACC_Y_OFFSET:  r_off_y <= $signed(i_cfg.data[ANG_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign i_sample.ready = (r_state == S_IDLE);
    assign w_load = (r_state == S_COMMIT) && (!r_out_valid || o_tilt.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_sample.valid) n_state = S_FEED_A;
            S_FEED_A: n_state = S_FEED_B;
            S_FEED_B: n_state = S_WAIT;
            S_WAIT:   if (w_vld[N_CELLS] && r_got_a) n_state = S_FILTER;
            S_FILTER: if (w_done_x) n_state = S_COMMIT;
            S_COMMIT: if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_got_a      <= 1'b0;
            r_filt_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_filt_start <= (r_state == S_WAIT) && w_vld[N_CELLS] && r_got_a;
            if (w_vld[N_CELLS]) begin
                r_got_a <= !r_got_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_gx <= i_sample.gyro_x;
            r_gy <= i_sample.gyro_y;
            r_ax <= i_sample.acc_x;
            r_ay <= i_sample.acc_y;
            r_az <= i_sample.acc_z;
        end
    end

    // ---------------- pre-rotation into the cell row ----------------
    // first vector (acc_y, acc_z) gives the X angle, second (acc_x, acc_z) the Y angle
    assign w_num   = (r_state == S_FEED_A) ? r_ay : r_ax;
    assign w_num_s = {{(XY_W-IN_W-16){w_num[IN_W-1]}}, w_num, 16'b0};
    assign w_den_s = {{(XY_W-IN_W-16){r_az[IN_W-1]}}, r_az, 16'b0};
    assign w_vld[0] = (r_state == S_FEED_A) || (r_state == S_FEED_B);

    always_comb begin
        w_vec[0].zero = (w_num == '0) && (r_az == '0);
        if (r_az[IN_W-1] && !w_num[IN_W-1]) begin
            w_vec[0].x = w_num_s;
            w_vec[0].y = -w_den_s;
            w_vec[0].z = Z_QUARTER;
        end else if (r_az[IN_W-1]) begin
            w_vec[0].x = -w_num_s;
            w_vec[0].y = w_den_s;
            w_vec[0].z = -Z_QUARTER;
        end else begin
            w_vec[0].x = w_den_s;
            w_vec[0].y = w_num_s;
            w_vec[0].z = '0;
        end
    end

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        tctf_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_vld[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    // ---------------- round, offset, wrap ----------------
    assign w_zr   = w_vec[N_CELLS].z + Z_W'(128);
    assign w_q    = w_vec[N_CELLS].zero ? '0 : w_zr[Z_W-1:8];
    assign w_off  = r_got_a ? r_off_y : r_off_x;
    assign w_sum  = SUM_W'(w_q) + HALF_TURN + SUM_W'(w_off);
    assign w_wrap = (w_sum > HALF_TURN) ? ANG_W'(w_sum - FULL_TURN) : w_sum[ANG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_vld[N_CELLS]) begin
            if (r_got_a) begin
                r_acc_y <= w_wrap;
            end else begin
                r_acc_x <= w_wrap;
            end
        end
    end

    // ---------------- filter lanes ----------------
    assign w_ctrl.start  = r_filt_start;
    assign w_ctrl.commit = w_load;

    tctf_filter_axis u_filt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_gyro  (r_gx),
        .i_acc   (r_acc_x),
        .i_alpha (r_alpha),
        .i_scale (r_scale),
        .o_done  (w_done_x),
        .o_angle (w_ang_x)
    );

    tctf_filter_axis u_filt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_gyro  (r_gy),
        .i_acc   (r_acc_y),
        .i_alpha (r_alpha),
        .i_scale (r_scale),
        .o_done  (w_done_y),
        .o_angle (w_ang_y)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_tilt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // both lanes run in lockstep; done of Y has no effect on the load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tilt_x <= w_ang_x;
            r_tilt_y <= w_ang_y;
            r_out_ax <= r_acc_x;
            r_out_ay <= r_acc_y;
        end else if (w_done_y) begin
            r_out_ay <= r_out_ay;
        end
    end

    assign o_tilt.valid         = r_out_valid;
    assign o_tilt.tilt_x        = r_tilt_x;
    assign o_tilt.tilt_y        = r_tilt_y;
    assign o_tilt.accel_angle_x = r_out_ax;
    assign o_tilt.accel_angle_y = r_out_ay;

endmodule

`default_nettype wire

// File: tb/imu_complementary_tilt_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_tb - self-checking bench of the tilt filter
// Drives IMU samples and register writes. A behavioral model of the CORDIC,
// the offset/wrap and the complementary filter predicts each tilt
// transaction. Both channels idle at random. Results are checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_tilt_filter_tb;
    import tctf_pkg::*;

    localparam int      STEPS      = 16;
    localparam longint  HALF_TURN  = 46080;   // 180 degrees in 1/256 degree
    localparam longint  FULL_TURN  = 92160;
    localparam longint  TILT_LIMIT = 1048576; // 4096 degrees
    localparam longint  RUN_LIMIT  = 10_000_000;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
    } t_imu_sample;

    typedef struct packed {
        logic signed [21:0] tilt_x;
        logic signed [21:0] tilt_y;
        logic signed [16:0] accel_x;
        logic signed [16:0] accel_y;
    } t_tilt;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tctf_in_if  smp_if ();
    tctf_out_if tilt_if ();
    tctf_cfg_if cfg_if ();

    imu_complementary_tilt_filter #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp_if),
        .o_tilt  (tilt_if),
        .i_cfg   (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    // model copy of the registers and the filter state
    logic [15:0]        wt_alpha;
    logic [23:0]        gyro_gain;
    logic signed [16:0] ofs_x;
    logic signed [16:0] ofs_y;
    logic signed [21:0] est_tilt_x;
    logic signed [21:0] est_tilt_y;

    t_tilt pending_tilt[$];
    t_tilt want_tilt;
    int    fail_cnt;
    bit    tx_gap_on;
    bit    rx_stall_on;
    int    rx_hold;

    // atan(2^-i) in 1/65536 degree
    function automatic longint atan_step(int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            16: return 57;
            17: return 29;
            18: return 14;
            19: return 7;
            20: return 4;
            21: return 2;
            22: return 1;
            default: return 0;
        endcase
    endfunction

    // vectoring CORDIC, result in 1/256 degree
    function automatic longint cordic_atan2(longint yv, longint xv);
        longint xa, ya, za, xs, ys, tmp;
        int     i;
        if (xv == 0 && yv == 0)
            return 0;
        xa = xv * 65536;
        ya = yv * 65536;
        za = 0;
        // left half plane: pre-rotate by +/-90 degrees
        if (xa < 0) begin
            tmp = xa;
            if (ya >= 0) begin
                xa = ya;
                ya = -tmp;
                za = 90 * 65536;
            end else begin
                xa = -ya;
                ya = tmp;
                za = -90 * 65536;
            end
        end
        for (i = 0; i < STEPS && i < 24; i++) begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya >= 0) begin
                xa = xa + ys;
                ya = ya - xs;
                za = za + atan_step(i);
            end else begin
                xa = xa - ys;
                ya = ya + xs;
                za = za - atan_step(i);
            end
        end
        return (za + 128) >>> 8;
    endfunction

    function automatic longint accel_angle(longint num, longint den,
                                           logic signed [16:0] ofs);
        longint a;
        a = cordic_atan2(num, den) + HALF_TURN + ofs;
        if (a > HALF_TURN)
            a = a - FULL_TURN;
        return a;
    endfunction

    function automatic longint filter_step(longint ang, longint gyro, longint acc);
        longint alpha, gain, s, t, r;
        alpha = wt_alpha;
        gain  = gyro_gain;
        s = ang * 65536 + gyro * gain;
        t = alpha * s + (65536 - alpha) * (acc * 65536);
        r = (t + 64'sd2147483648) >>> 32;
        if (r > TILT_LIMIT)
            r = TILT_LIMIT;
        if (r < -TILT_LIMIT)
            r = -TILT_LIMIT;
        return r;
    endfunction

    // advances the model state by one sample
    function automatic t_tilt next_tilt(t_imu_sample smp);
        t_tilt  res;
        longint ang_x, ang_y;
        ang_x = accel_angle($signed(smp.acc_y), $signed(smp.acc_z), ofs_x);
        ang_y = accel_angle($signed(smp.acc_x), $signed(smp.acc_z), ofs_y);
        est_tilt_x = 22'(filter_step(est_tilt_x, $signed(smp.gyro_x), ang_x));
        est_tilt_y = 22'(filter_step(est_tilt_y, $signed(smp.gyro_y), ang_y));
        res.tilt_x  = est_tilt_x;
        res.tilt_y  = est_tilt_y;
        res.accel_x = ang_x[16:0];
        res.accel_y = ang_y[16:0];
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(16, 64);
        return $urandom_range(0, 3);
    endfunction

    function automatic t_imu_sample make_sample(int gx, int gy, int ax, int ay, int az);
        t_imu_sample smp;
        smp.gyro_x = gx[15:0];
        smp.gyro_y = gy[15:0];
        smp.acc_x  = ax[15:0];
        smp.acc_y  = ay[15:0];
        smp.acc_z  = az[15:0];
        return smp;
    endfunction

    function automatic logic [15:0] rand_acc(int kind);
        case (kind)
            0: return 16'($urandom_range(0, 128) - 64);
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_sample rand_sample();
        t_imu_sample smp;
        int          sel;
        sel = $urandom_range(0, 9);
        smp.gyro_x = 16'($urandom);
        smp.gyro_y = 16'($urandom);
        if (sel < 7) begin
            smp.acc_x = 16'($urandom);
            smp.acc_y = 16'($urandom);
            smp.acc_z = 16'($urandom);
        end else if (sel == 7) begin
            // small magnitudes near the origin
            smp.acc_x = rand_acc(0);
            smp.acc_y = rand_acc(0);
            smp.acc_z = rand_acc(0);
            smp.gyro_x = 16'($urandom_range(0, 32) - 16);
            smp.gyro_y = 16'($urandom_range(0, 32) - 16);
        end else if (sel == 8) begin
            // axis cases: some components zero
            smp.acc_x = $urandom_range(0, 1) ? 16'h0000 : rand_acc(2);
            smp.acc_y = $urandom_range(0, 1) ? 16'h0000 : rand_acc(2);
            smp.acc_z = $urandom_range(0, 1) ? 16'h0000 : rand_acc(2);
        end else begin
            smp.acc_x = rand_acc(1);
            smp.acc_y = rand_acc(1);
            smp.acc_z = rand_acc(1);
        end
        return smp;
    endfunction

    // sample channel: valid stays high across back-to-back transactions
    task automatic send_sample(input t_imu_sample smp);
        int gap;
        gap = tx_gap_on ? gap_len() : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            smp_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        smp_if.valid  <= 1'b1;
        smp_if.gyro_x <= smp.gyro_x;
        smp_if.gyro_y <= smp.gyro_y;
        smp_if.acc_x  <= smp.acc_x;
        smp_if.acc_y  <= smp.acc_y;
        smp_if.acc_z  <= smp.acc_z;
        @(posedge i_clk);
        while (!smp_if.ready)
            @(posedge i_clk);
        pending_tilt.push_back(next_tilt(smp));
    endtask

    task automatic drain_samples();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (pending_tilt.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] data);
        drain_samples();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            REG_FILTER_WEIGHT: wt_alpha  = data[15:0];
            REG_GYRO_SCALE:    gyro_gain = data;
            REG_ACC_X_OFFSET:  ofs_x     = data[16:0];
            REG_ACC_Y_OFFSET:  ofs_y     = data[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // reset defaults: zero vector, negative x axis, quadrants, extremes
    task automatic test_directed_samples();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        send_sample(make_sample(0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, -32768));
        send_sample(make_sample(0, 0, 0, 0, 32767));
        send_sample(make_sample(0, 0, 32767, -32768, 0));
        send_sample(make_sample(0, 0, -32768, 32767, -32768));
        send_sample(make_sample(0, 0, -32768, -32768, -32768));
        send_sample(make_sample(0, 0, 1000, 0, 0));
        send_sample(make_sample(0, 0, -1, -1, -1));
        send_sample(make_sample(0, 0, 1, 1, 1));
        send_sample(make_sample(0, 0, -1, 1, -1));
        send_sample(make_sample(32767, -32768, 0, 0, 0));
        send_sample(make_sample(-32768, 32767, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
    endtask

    // pure accel path, then full gyro weight driven into saturation
    task automatic test_weight_extremes();
        write_reg(REG_FILTER_WEIGHT, 24'hab0000);
        send_sample(make_sample(32767, -32768, 500, -700, 300));
        write_reg(REG_FILTER_WEIGHT, 24'h00ffff);
        write_reg(REG_GYRO_SCALE, 24'hffffff);
        send_sample(make_sample(32767, -32768, 0, 0, 100));
        send_sample(make_sample(32767, -32768, 0, 0, 100));
        send_sample(make_sample(-32768, 32767, 0, 0, 100));
        write_reg(REG_GYRO_SCALE, 24'h000000);
        send_sample(make_sample(-32768, 32767, 100, 100, -100));
    endtask

    // offsets at the wrap limits and at the 17-bit extremes
    task automatic test_offset_extremes();
        write_reg(REG_FILTER_WEIGHT, 24'h00fae1);
        write_reg(REG_GYRO_SCALE, 24'h005bc0);
        write_reg(REG_ACC_X_OFFSET, 24'h00b400);
        write_reg(REG_ACC_Y_OFFSET, 24'h01_4c00);
        send_sample(make_sample(0, 0, 0, 0, -32768));
        send_sample(make_sample(0, 0, 0, 0, 32767));
        write_reg(REG_ACC_X_OFFSET, 24'hfe_ffff);
        write_reg(REG_ACC_Y_OFFSET, 24'h01_0000);
        send_sample(make_sample(0, 0, 0, 0, -32768));
        send_sample(make_sample(100, -100, 20000, -20000, 5000));
        send_sample(make_sample(0, 0, 0, 0, 0));
    endtask

    task automatic random_config();
        logic [15:0] alpha;
        logic [23:0] scale;
        logic [16:0] ox, oy;
        case ($urandom_range(0, 4))
            0: alpha = 16'h0000;
            1: alpha = 16'hffff;
            2: alpha = 16'd64225;
            3: alpha = 16'($urandom_range(60000, 65535));
            default: alpha = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: scale = 24'h000000;
            1: scale = 24'hffffff;
            2: scale = 24'd23488;
            3: scale = 24'($urandom_range(0, 200000));
            default: scale = 24'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: ox = 17'(-46080);
            1: ox = 17'(46080);
            2: ox = 17'($urandom);
            default: ox = 17'($urandom_range(0, 92160) - 46080);
        endcase
        case ($urandom_range(0, 4))
            0: oy = 17'(-46080);
            1: oy = 17'(46080);
            2: oy = 17'($urandom);
            default: oy = 17'($urandom_range(0, 92160) - 46080);
        endcase
        write_reg(REG_FILTER_WEIGHT, {8'($urandom), alpha});
        write_reg(REG_GYRO_SCALE, scale);
        write_reg(REG_ACC_X_OFFSET, {7'($urandom), ox});
        write_reg(REG_ACC_Y_OFFSET, {7'($urandom), oy});
    endtask

    task automatic test_random_phases();
        int ph, k, n;
        for (ph = 0; ph < 10; ph++) begin
            random_config();
            tx_gap_on   = (ph % 3) != 1;
            rx_stall_on = (ph % 3) != 2;
            n = $urandom_range(120, 180);
            for (k = 0; k < n; k++) begin
                // hold off until the filter has fully caught up
                if (k == n / 2 || $urandom_range(0, 99) == 0)
                    drain_samples();
                send_sample(rand_sample());
            end
        end
    endtask

    task automatic finish_run();
        drain_samples();
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        if (rx_hold == 0 && rx_stall_on && $urandom_range(0, 3) == 0)
            rx_hold = gap_len();
        if (rx_hold != 0) begin
            tilt_if.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            tilt_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tilt_if.valid && tilt_if.ready) begin
            if (pending_tilt.size() == 0) begin
                $error("tilt transaction with nothing expected");
                fail_cnt++;
            end else begin
                want_tilt = pending_tilt.pop_front();
                if (tilt_if.tilt_x !== want_tilt.tilt_x) begin
                    $error("tilt_x: expected %0d, got %0d", want_tilt.tilt_x, tilt_if.tilt_x);
                    fail_cnt++;
                end
                if (tilt_if.tilt_y !== want_tilt.tilt_y) begin
                    $error("tilt_y: expected %0d, got %0d", want_tilt.tilt_y, tilt_if.tilt_y);
                    fail_cnt++;
                end
                if (tilt_if.accel_angle_x !== want_tilt.accel_x) begin
                    $error("accel_angle_x: expected %0d, got %0d",
                           want_tilt.accel_x, tilt_if.accel_angle_x);
                    fail_cnt++;
                end
                if (tilt_if.accel_angle_y !== want_tilt.accel_y) begin
                    $error("accel_angle_y: expected %0d, got %0d",
                           want_tilt.accel_y, tilt_if.accel_angle_y);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        smp_if.valid   = 1'b0;
        smp_if.gyro_x  = '0;
        smp_if.gyro_y  = '0;
        smp_if.acc_x   = '0;
        smp_if.acc_y   = '0;
        smp_if.acc_z   = '0;
        tilt_if.ready  = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_FILTER_WEIGHT;
        cfg_if.data    = '0;
        tx_gap_on      = 1'b0;
        rx_stall_on    = 1'b0;
        rx_hold        = 0;
        fail_cnt       = 0;
        wt_alpha       = 16'd64225;
        gyro_gain      = 24'd23488;
        ofs_x          = -17'sd819;
        ofs_y          = 17'sd768;
        est_tilt_x     = '0;
        est_tilt_y     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_samples();
        test_weight_extremes();
        test_offset_extremes();
        test_random_phases();
        finish_run();
    end

endmodule

`default_nettype wire

// File: imu_complementary_tilt_filter.f
rtl/tctf_pkg.sv
rtl/tctf_if.sv
rtl/tctf_cordic_cell.sv
rtl/tctf_filter_axis.sv
rtl/imu_complementary_tilt_filter.sv
tb/imu_complementary_tilt_filter_tb.sv
